@@ design/sdct_pkg.sv @@
`default_nettype none

package sdct_pkg;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // frame shape: start byte then payload byte
    localparam int FRAME_BITS = 16;
    localparam int BIT_CNT_W  = $clog2(FRAME_BITS);

    localparam int CFG_DATA_W = 7;

    localparam logic [7:0] START_CMD  = 8'hF8;
    localparam logic [7:0] START_DATA = 8'hFA;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;

    localparam logic [7:0] MASK_ENTRY    = 8'hFC;
    localparam logic [7:0] MASK_DISPCTL  = 8'hF8;
    localparam logic [7:0] MASK_FUNCTION = 8'hE0;
    localparam logic [7:0] CODE_ENTRY    = 8'h04;
    localparam logic [7:0] CODE_DISPCTL  = 8'h08;
    localparam logic [7:0] CODE_FUNCTION = 8'h20;
    localparam logic [7:0] ENTRY_CLEARED = 8'h06;
    localparam logic [7:0] ENTRY_SHIFT   = 8'h01;
    localparam logic [7:0] DISP_ON_BIT   = 8'h04;
    localparam logic [7:0] BRIGHT_MASK   = 8'hFC;

    localparam logic [7:0] DDRAM_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'h40;

    localparam logic [7:0] ENTRY_RESET    = 8'h06;
    localparam logic [7:0] DISPCTL_RESET  = 8'h0C;
    localparam logic [7:0] FUNCTION_RESET = 8'h38;

    localparam logic [1:0] LINE_COUNT_RESET   = 2'd2;
    localparam logic [6:0] COLUMN_COUNT_RESET = 7'd20;

    localparam logic [7:0] PCT_STEP_25 = 8'd25;
    localparam logic [7:0] PCT_STEP_50 = 8'd50;
    localparam logic [7:0] PCT_STEP_75 = 8'd75;

    typedef enum logic [0:0] {
        CFG_LINE_COUNT   = 1'b0,
        CFG_COLUMN_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_RAW_CMD  = 3'd0,
        KIND_RAW_DATA = 3'd1,
        KIND_CLEAR    = 3'd2,
        KIND_HOME     = 3'd3,
        KIND_DISP_ON  = 3'd4,
        KIND_DISP_OFF = 3'd5,
        KIND_CURSOR   = 3'd6,
        KIND_BRIGHT   = 3'd7
    } kind_t;

    // how the back turns a queued request into its payload byte
    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_DISP_ON  = 2'd1,
        OP_DISP_OFF = 2'd2,
        OP_BRIGHT   = 2'd3
    } op_t;

    typedef struct packed {
        logic       err;
        logic       is_cmd;
        op_t        op;
        logic [7:0] value;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_BITS = 2'd1,
        BK_STOP = 2'd2
    } bk_state_t;

    typedef enum logic [1:0] {
        SUB_SET  = 2'd0,
        SUB_LOW  = 2'd1,
        SUB_HIGH = 2'd2
    } sub_t;

endpackage

`default_nettype wire

@@ design/sdct_front.sv @@
`default_nettype none

module sdct_front
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [0:0]                       cfg_index,
    input  wire logic [sdct_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [2:0]                       kind,
    input  wire logic [7:0]                       payload,
    input  wire logic [6:0]                       column,
    input  wire logic                             row,
    input  wire logic [7:0]                       brightness_pct,
    input  wire sdct_pkg::q_status_t              q_status,
    output logic                                  push,
    output sdct_pkg::req_t                        req
);

    logic [1:0] line_count_reg;
    logic [6:0] column_count_reg;
    logic [1:0] bright_code;
    logic       cursor_bad;
    logic [7:0] cursor_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg   <= sdct_pkg::LINE_COUNT_RESET;
            column_count_reg <= sdct_pkg::COLUMN_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (sdct_pkg::cfg_index_t'(cfg_index))
                sdct_pkg::CFG_LINE_COUNT:   line_count_reg   <= cfg_data[1:0];
                sdct_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data[6:0];
            endcase
        end
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    assign cursor_bad  = ({1'b0, row} >= line_count_reg) || (column >= column_count_reg);
    assign cursor_addr = sdct_pkg::DDRAM_BASE + (row ? sdct_pkg::ROW1_BASE : 8'h00)
                         + {1'b0, column};

    always_comb
    begin
        priority if (brightness_pct <= sdct_pkg::PCT_STEP_25) bright_code = 2'd3;
        else if (brightness_pct <= sdct_pkg::PCT_STEP_50)     bright_code = 2'd2;
        else if (brightness_pct <= sdct_pkg::PCT_STEP_75)     bright_code = 2'd1;
        else                                                  bright_code = 2'd0;
    end

    always_comb
    begin
        req.err    = 1'b0;
        req.is_cmd = 1'b1;
        req.op     = sdct_pkg::OP_BYTE;
        req.value  = payload;
        unique case (sdct_pkg::kind_t'(kind))
            sdct_pkg::KIND_RAW_CMD:  req.value = payload;
            sdct_pkg::KIND_RAW_DATA: req.is_cmd = 1'b0;
            sdct_pkg::KIND_CLEAR:    req.value = sdct_pkg::CMD_CLEAR;
            sdct_pkg::KIND_HOME:     req.value = sdct_pkg::CMD_HOME;
            sdct_pkg::KIND_DISP_ON:  req.op = sdct_pkg::OP_DISP_ON;
            sdct_pkg::KIND_DISP_OFF: req.op = sdct_pkg::OP_DISP_OFF;
            sdct_pkg::KIND_CURSOR:
            begin
                req.err   = cursor_bad;
                req.value = cursor_addr;
            end
            sdct_pkg::KIND_BRIGHT:
            begin
                req.op    = sdct_pkg::OP_BRIGHT;
                req.value = {6'd0, bright_code};
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/sdct_queue.sv @@
`default_nettype none

module sdct_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sdct_pkg::req_t  push_req,
    input  wire logic            pop,
    output sdct_pkg::req_t       head,
    output sdct_pkg::q_status_t  q_status
);

    localparam int PW = sdct_pkg::QPTR_W;
    localparam int CW = sdct_pkg::QCNT_W;

    sdct_pkg::req_t entry_reg [sdct_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        if (p == PW'(sdct_pkg::QUEUE_DEPTH - 1))
            return '0;
        return p + PW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_req;
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CW'(sdct_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ design/sdct_back.sv @@
`default_nettype none

module sdct_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sdct_pkg::req_t       head,
    input  wire sdct_pkg::q_status_t  q_status,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      stb_level,
    output logic                      sck_level,
    output logic                      sdata_level,
    output logic                      last,
    output logic                      status
);

    localparam int BW = sdct_pkg::BIT_CNT_W;

    sdct_pkg::bk_state_t state_reg, state_next;
    sdct_pkg::sub_t      sub_reg, sub_next;
    logic [BW-1:0]       bit_reg, bit_next;
    logic                out_valid_reg, out_valid_next;
    logic                data_level_reg, data_level_next;
    logic [7:0]          entry_reg, entry_next;
    logic [7:0]          dispctl_reg, dispctl_next;
    logic [7:0]          function_reg, function_next;

    // payload registers
    logic [sdct_pkg::FRAME_BITS-1:0] frame_reg, frame_next;
    logic [7:0] cmd_byte_reg, cmd_byte_next;
    logic       is_cmd_reg, is_cmd_next;
    logic       stb_reg, stb_next;
    logic       sck_reg, sck_next;
    logic       sdata_reg, sdata_next;
    logic       last_reg, last_next;
    logic       status_reg, status_next;

    logic       advance;
    logic [7:0] byte_val;

    assign advance = !out_valid_reg || !out_stall;

    // payload byte, resolved against the shadows current at frame start
    always_comb
    begin
        unique case (head.op)
            sdct_pkg::OP_BYTE:     byte_val = head.value;
            sdct_pkg::OP_DISP_ON:  byte_val = dispctl_reg | sdct_pkg::DISP_ON_BIT;
            sdct_pkg::OP_DISP_OFF: byte_val = dispctl_reg & ~sdct_pkg::DISP_ON_BIT;
            sdct_pkg::OP_BRIGHT:
                byte_val = (function_reg & sdct_pkg::BRIGHT_MASK) | head.value;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        sub_next        = sub_reg;
        bit_next        = bit_reg;
        out_valid_next  = out_valid_reg;
        data_level_next = data_level_reg;
        entry_next      = entry_reg;
        dispctl_next    = dispctl_reg;
        function_next   = function_reg;
        frame_next      = frame_reg;
        cmd_byte_next   = cmd_byte_reg;
        is_cmd_next     = is_cmd_reg;
        stb_next        = stb_reg;
        sck_next        = sck_reg;
        sdata_next      = sdata_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        pop             = 1'b0;

        unique case (state_reg)
            sdct_pkg::BK_IDLE:
            begin
                if (advance)
                begin
                    out_valid_next = !q_status.empty;
                    if (!q_status.empty)
                    begin
                        pop        = 1'b1;
                        sck_next   = 1'b1;
                        sdata_next = data_level_reg;
                        if (head.err)
                        begin
                            // rejected cursor: one result, nothing sent
                            stb_next    = 1'b1;
                            last_next   = 1'b1;
                            status_next = 1'b1;
                        end
                        else
                        begin
                            stb_next      = 1'b0;
                            last_next     = 1'b0;
                            status_next   = 1'b0;
                            is_cmd_next   = head.is_cmd;
                            cmd_byte_next = byte_val;
                            frame_next    = {head.is_cmd ? sdct_pkg::START_CMD
                                                         : sdct_pkg::START_DATA, byte_val};
                            sub_next      = sdct_pkg::SUB_SET;
                            bit_next      = '0;
                            state_next    = sdct_pkg::BK_BITS;
                        end
                    end
                end
            end
            sdct_pkg::BK_BITS:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    stb_next       = 1'b0;
                    last_next      = 1'b0;
                    status_next    = 1'b0;
                    sdata_next     = data_level_reg;
                    unique case (sub_reg)
                        sdct_pkg::SUB_SET:
                        begin
                            data_level_next = frame_reg[sdct_pkg::FRAME_BITS-1];
                            sdata_next      = frame_reg[sdct_pkg::FRAME_BITS-1];
                            sck_next        = 1'b1;
                            sub_next        = sdct_pkg::SUB_LOW;
                        end
                        sdct_pkg::SUB_LOW:
                        begin
                            sck_next = 1'b0;
                            sub_next = sdct_pkg::SUB_HIGH;
                        end
                        sdct_pkg::SUB_HIGH:
                        begin
                            sck_next   = 1'b1;
                            sub_next   = sdct_pkg::SUB_SET;
                            frame_next = {frame_reg[sdct_pkg::FRAME_BITS-2:0], 1'b0};
                            if (bit_reg == BW'(sdct_pkg::FRAME_BITS - 1))
                                state_next = sdct_pkg::BK_STOP;
                            else
                                bit_next = bit_reg + BW'(1);
                        end
                        default:
                        begin
                            sub_next = sdct_pkg::SUB_SET;
                        end
                    endcase
                end
            end
            sdct_pkg::BK_STOP:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    stb_next       = 1'b1;
                    sck_next       = 1'b1;
                    sdata_next     = data_level_reg;
                    last_next      = 1'b1;
                    status_next    = 1'b0;
                    state_next     = sdct_pkg::BK_IDLE;
                    if (is_cmd_reg)
                    begin
                        priority if (cmd_byte_reg == sdct_pkg::CMD_CLEAR)
                            entry_next = sdct_pkg::ENTRY_CLEARED
                                         | (entry_reg & sdct_pkg::ENTRY_SHIFT);
                        else if ((cmd_byte_reg & sdct_pkg::MASK_ENTRY) == sdct_pkg::CODE_ENTRY)
                            entry_next = cmd_byte_reg;
                        else if ((cmd_byte_reg & sdct_pkg::MASK_DISPCTL)
                                 == sdct_pkg::CODE_DISPCTL)
                            dispctl_next = cmd_byte_reg;
                        else if ((cmd_byte_reg & sdct_pkg::MASK_FUNCTION)
                                 == sdct_pkg::CODE_FUNCTION)
                            function_next = cmd_byte_reg;
                        else
                            entry_next = entry_reg;
                    end
                end
            end
            default:
            begin
                state_next = sdct_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sdct_pkg::BK_IDLE;
            sub_reg        <= sdct_pkg::SUB_SET;
            bit_reg        <= '0;
            out_valid_reg  <= 1'b0;
            data_level_reg <= 1'b0;
            entry_reg      <= sdct_pkg::ENTRY_RESET;
            dispctl_reg    <= sdct_pkg::DISPCTL_RESET;
            function_reg   <= sdct_pkg::FUNCTION_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            sub_reg        <= sub_next;
            bit_reg        <= bit_next;
            out_valid_reg  <= out_valid_next;
            data_level_reg <= data_level_next;
            entry_reg      <= entry_next;
            dispctl_reg    <= dispctl_next;
            function_reg   <= function_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        cmd_byte_reg <= cmd_byte_next;
        is_cmd_reg   <= is_cmd_next;
        stb_reg      <= stb_next;
        sck_reg      <= sck_next;
        sdata_reg    <= sdata_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign stb_level   = stb_reg;
    assign sck_level   = sck_reg;
    assign sdata_level = sdata_reg;
    assign last        = last_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

@@ design/serial_display_command_transmitter.sv @@
`default_nettype none

// channel   direction  handshake              payload
// request   in         in_valid / in_stall    kind, payload, column, row, brightness_pct
// phase     out        out_valid / out_stall  stb_level, sck_level, sdata_level, last, status
// config    in         cfg_write              cfg_index, cfg_data
//
// a frame request gives 50 pin phases, one per cycle while out_stall is low;
// the bit sequencer in the back end sets that figure
// a rejected cursor request gives a single error phase
// a two-entry queue lets new requests be taken while a frame is still shifting
// reset restores the shadow registers, line and column counts and the held data level low
// an output stall freezes the sequencer; an input stall is raised only while the queue is full

module serial_display_command_transmitter
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             cfg_write,
    input  wire logic [0:0]                       cfg_index,
    input  wire logic [sdct_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [2:0]                       kind,
    input  wire logic [7:0]                       payload,
    input  wire logic [6:0]                       column,
    input  wire logic                             row,
    input  wire logic [7:0]                       brightness_pct,
    // pin phase channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  stb_level,
    output logic                                  sck_level,
    output logic                                  sdata_level,
    output logic                                  last,
    output logic                                  status
);

    // classified request from the front end
    sdct_pkg::req_t      front_req;
    // oldest queued request, seen by the back end
    sdct_pkg::req_t      head_req;
    sdct_pkg::q_status_t q_status;
    logic                push;
    logic                pop;

    // front: config registers, cursor range check, opcode and byte building
    sdct_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .payload        (payload),
        .column         (column),
        .row            (row),
        .brightness_pct (brightness_pct),
        .q_status       (q_status),
        .push           (push),
        .req            (front_req)
    );

    // short queue decoupling request intake from frame shifting
    sdct_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (front_req),
        .pop      (pop),
        .head     (head_req),
        .q_status (q_status)
    );

    // back: shadow registers, frame shifter and registered pin phase output
    sdct_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_req),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stb_level   (stb_level),
        .sck_level   (sck_level),
        .sdata_level (sdata_level),
        .last        (last),
        .status      (status)
    );

endmodule

`default_nettype wire

@@ design/sdct_checker.sv @@
`default_nettype none

module sdct_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic stb_level,
    input wire logic sck_level,
    input wire logic sdata_level,
    input wire logic last,
    input wire logic status
);

    // an error phase is a lone idle-level phase that ends its request
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && stb_level && sck_level)
        else $error("error phase not idle-level or not last");

    // the stop phase of a frame raises the strobe
    a_stop_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !status |-> stb_level)
        else $error("final frame phase with strobe low");

    // inside a frame the phases follow without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && !status)
        else $error("gap inside a frame");

    // a clock-low phase is always followed by a clock-high phase of the same frame
    a_sck_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !sck_level |=> sck_level && !stb_level
                                                  && $stable(sdata_level))
        else $error("clock low not followed by rising edge on same data");

    // a stalled phase holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(stb_level) && $stable(sck_level)
                                   && $stable(sdata_level) && $stable(last)
                                   && $stable(status))
        else $error("stalled phase changed");

endmodule

bind serial_display_command_transmitter sdct_checker u_sdct_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stb_level   (stb_level),
    .sck_level   (sck_level),
    .sdata_level (sdata_level),
    .last        (last),
    .status      (status)
);

`default_nettype wire
